/* rtl/rkq_pkg.sv */
// Shared types, constants and helpers of the bounded top-K ranker.
// No dependencies; every other file uses this package.
package rkq_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int TAG_BITS    = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SCALE       = 1000;
  localparam int CAL_W       = 48;
  localparam int Q_W         = 39;
  localparam int DIV_STEPS   = 4;
  localparam int DIVC_W      = $clog2(DIV_STEPS + 1);
  localparam int KEY_W       = 3 * 10 + CAL_W + 12 + 64;
  localparam int ADDR_W      = 3;

  // score / 1000 as (|score| >> 3) * ceil(2^52 / 125) >> 52, four 24x24 products
  localparam int MUL_W     = 24;
  localparam int PRE_SH    = 3;
  localparam int SCALE_ODD = SCALE >> PRE_SH;
  localparam int RECIP_SH  = 52;
  localparam int ACC_W     = 4 * MUL_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << RECIP_SH) + 64'(SCALE_ODD - 1)) / 64'(SCALE_ODD);
  localparam logic [MUL_W-1:0] RECIP_LO = RECIP[MUL_W-1:0];
  localparam logic [MUL_W-1:0] RECIP_HI = RECIP[2*MUL_W-1:MUL_W];

  localparam logic [7:0] CAP_RESET = 8'd128;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic REG_RANK_MODE = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

  typedef enum logic [1:0] {
    MODE_STRICT = 2'd0,
    MODE_PROXY  = 2'd1,
    MODE_CALIB  = 2'd2,
    MODE_XOR    = 2'd3
  } rank_mode_e;

  typedef struct packed {
    logic               cmd;
    logic [9:0]         strict_cost;
    logic [9:0]         proxy_cost;
    logic [9:0]         xor_cost;
    logic signed [47:0] calibrated_score;
    logic [11:0]        weight_total;
    logic [63:0]        hash_value;
    logic [15:0]        tag;
    logic [6:0]         rank_index;
  } in_item_t;

  typedef struct packed {
    logic               entry_valid;
    logic [9:0]         out_strict;
    logic [9:0]         out_proxy;
    logic [9:0]         out_xor;
    logic signed [47:0] out_calibrated;
    logic [11:0]        out_weight;
    logic [63:0]        out_hash;
    logic [15:0]        out_tag;
    logic [7:0]         entry_count;
    logic               replaced;
    logic               evicted;
  } out_item_t;

  typedef struct packed {
    logic          load;
    logic          div_step;
    logic          scan_init;
    logic          scan_step;
    logic          decide;
    logic          shift_rd;
    logic          shift_wr;
    logic          wr_new;
    logic          rd_entry;
    logic          res_load;
  } rkq_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic skip_write;
    logic replaced;
    logic shift_done;
  } rkq_status_t;

  function automatic logic [CNT_W-1:0] eff_cap(input logic [7:0] raw);
    logic [CNT_W-1:0] r;
    if (raw == 8'd0) begin
      r = CNT_W'(1);
    end else if (int'(raw) > MAX_ENTRIES) begin
      r = CNT_W'(MAX_ENTRIES);
    end else begin
      r = CNT_W'(raw);
    end
    return r;
  endfunction

endpackage

/* rtl/rkq_if.sv */
// Valid/ready channel interfaces for ranker commands and results.
// Depends on rkq_pkg for the payload types.
interface rkq_in_if;
  logic              valid;
  logic              ready;
  rkq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rkq_out_if;
  logic               valid;
  logic               ready;
  rkq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/rkq_ctrl.sv */
// Sequencer of the ranker: divide, scan, decide, shift, write, respond; or read, respond.
// Depends on rkq_pkg; drives rkq_datapath through command/status structs.
module rkq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rkq_pkg::rkq_status_t sts_i,
  output rkq_pkg::rkq_cmd_t    cmd_o
);
  import rkq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SCAN, ST_DECIDE, ST_SH_RD, ST_SH_WR, ST_WRITE, ST_RD, ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i;
      ST_DIV:    begin
        cmd_o.div_step  = 1'b1;
        cmd_o.scan_init = sts_i.div_done;
      end
      ST_SCAN:   cmd_o.scan_step = 1'b1;
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_SH_RD:  cmd_o.shift_rd = !sts_i.shift_done;
      ST_SH_WR:  cmd_o.shift_wr = 1'b1;
      ST_WRITE:  cmd_o.wr_new = 1'b1;
      ST_RD:     cmd_o.rd_entry = 1'b1;
      ST_FIN:    cmd_o.res_load = slot_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_FIN) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= (in_cmd_i == CMD_READ) ? ST_RD : ST_DIV;
          end
        end
        ST_DIV: begin
          if (sts_i.div_done) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: state_q <= ST_SH_RD;
        ST_SH_RD: begin
          if (sts_i.skip_write) begin
            state_q <= ST_FIN;
          end else if (sts_i.replaced || sts_i.shift_done) begin
            state_q <= ST_WRITE;
          end else begin
            state_q <= ST_SH_WR;
          end
        end
        ST_SH_WR: state_q <= ST_SH_RD;
        ST_WRITE: state_q <= ST_FIN;
        ST_RD:    state_q <= ST_FIN;
        ST_FIN: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/rkq_datapath.sv */
// Entry store, key compare, reciprocal multiply for score/1000 and result register.
// Depends on rkq_pkg; sequenced by rkq_ctrl.
module rkq_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rkq_pkg::in_item_t       item_i,
  input  rkq_pkg::rank_mode_e     mode_i,
  input  logic [rkq_pkg::CNT_W-1:0] cap_i,
  input  logic                    cap_wr_i,
  input  logic [rkq_pkg::CNT_W-1:0] cap_new_i,
  input  rkq_pkg::rkq_cmd_t       cmd_i,
  output rkq_pkg::rkq_status_t    sts_o,
  output rkq_pkg::out_item_t      res_o
);
  import rkq_pkg::*;

  typedef struct packed {
    logic [9:0]          s;
    logic [9:0]          p;
    logic [9:0]          x;
    logic [CAL_W-1:0]    c;
    logic [Q_W-1:0]      q;
    logic [11:0]         w;
    logic [63:0]         h;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  function automatic logic [KEY_W-1:0] make_key(
    input rank_mode_e m, input entry_t e);
    logic [CAL_W-1:0] cf;
    logic [CAL_W-1:0] qe;
    logic [CAL_W-1:0] qf;
    logic [KEY_W-1:0] k;
    cf = {~e.c[CAL_W-1], e.c[CAL_W-2:0]};
    qe = {{(CAL_W - Q_W){e.q[Q_W-1]}}, e.q};
    qf = {~qe[CAL_W-1], qe[CAL_W-2:0]};
    case (m)
      MODE_STRICT: k = {e.s, e.p, e.x, qf, e.w, e.h};
      MODE_PROXY:  k = {e.p, e.s, e.x, qf, e.w, e.h};
      MODE_CALIB:  k = {cf, e.s, e.p, e.x, e.w, e.h};
      default:     k = {e.x, e.s, e.p, qf, e.w, e.h};
    endcase
    return k;
  endfunction

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_q;

  in_item_t           item_q;
  logic               neg_q;
  logic [2*MUL_W-1:0] mag_q;
  logic [ACC_W-1:0]   acc_q;
  logic [DIVC_W-1:0]  div_cnt_q;

  logic [CNT_W-1:0] fill_q;
  logic [CNT_W-1:0] rd_idx_q;
  logic             pv_q;
  logic [IDX_W-1:0] pidx_q;
  logic             eq_found_q, gt_found_q;
  logic [IDX_W-1:0] eq_pos_q, gt_pos_q;
  logic [CNT_W-1:0] pos_q, sh_idx_q;
  logic             replaced_q, evicted_q, skip_q;
  out_item_t        res_q;
  out_item_t        res_d;

  logic [CAL_W-1:0]   cal_abs;
  logic               a_hi, b_hi;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [ACC_W-1:0]   acc_add;
  logic [Q_W-1:0]     q_mag;
  logic [Q_W-1:0]     q_new;
  entry_t           new_e;
  logic [KEY_W-1:0] key_new, key_held;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           wr_data;
  logic [CNT_W-1:0] sh_prev;
  logic [CNT_W-1:0] pos_c;
  logic             scan_more;
  logic             rank_ok;

  assign cal_abs = item_i.calibrated_score[CAL_W-1] ?
                   (CAL_W'(0) - item_i.calibrated_score) : item_i.calibrated_score;
  assign a_hi    = (div_cnt_q <= DIVC_W'(DIV_STEPS / 2));
  assign b_hi    = div_cnt_q[0];
  assign mul_a   = a_hi ? mag_q[2*MUL_W-1:MUL_W] : mag_q[MUL_W-1:0];
  assign mul_b   = b_hi ? RECIP_HI : RECIP_LO;
  assign mul_p   = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
  assign q_mag   = acc_q[RECIP_SH +: Q_W];
  assign q_new   = neg_q ? (Q_W'(0) - q_mag) : q_mag;

  always_comb begin
    acc_add = ACC_W'(mul_p);
    if (a_hi) begin
      acc_add = acc_add << MUL_W;
    end
    if (b_hi) begin
      acc_add = acc_add << MUL_W;
    end
  end

  always_comb begin
    new_e.s   = item_q.strict_cost;
    new_e.p   = item_q.proxy_cost;
    new_e.x   = item_q.xor_cost;
    new_e.c   = item_q.calibrated_score;
    new_e.q   = q_new;
    new_e.w   = item_q.weight_total;
    new_e.h   = item_q.hash_value;
    new_e.tag = item_q.tag[TAG_BITS-1:0];
  end

  assign key_new  = make_key(mode_i, new_e);
  assign key_held = make_key(mode_i, rdata_q);
  assign scan_more = (rd_idx_q < fill_q);
  assign sh_prev   = sh_idx_q - CNT_W'(1);
  assign rank_ok   = (32'(item_q.rank_index) < 32'(fill_q));

  always_comb begin
    if (eq_found_q) begin
      pos_c = CNT_W'(eq_pos_q);
    end else if (gt_found_q) begin
      pos_c = CNT_W'(gt_pos_q);
    end else begin
      pos_c = fill_q;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_idx_q[IDX_W-1:0];
    if (cmd_i.scan_step && scan_more) begin
      rd_en = 1'b1;
    end else if (cmd_i.shift_rd) begin
      rd_en   = 1'b1;
      rd_addr = sh_prev[IDX_W-1:0];
    end else if (cmd_i.rd_entry) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(item_q.rank_index);
    end
    wr_en   = cmd_i.shift_wr || cmd_i.wr_new;
    wr_addr = cmd_i.shift_wr ? sh_idx_q[IDX_W-1:0] : pos_q[IDX_W-1:0];
    wr_data = cmd_i.shift_wr ? rdata_q : new_e;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
      neg_q  <= item_i.calibrated_score[CAL_W-1];
      mag_q  <= (2*MUL_W)'(cal_abs >> PRE_SH);
      acc_q  <= '0;
    end else if (cmd_i.div_step) begin
      acc_q <= acc_q + acc_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      div_cnt_q  <= '0;
      rd_idx_q   <= '0;
      pv_q       <= 1'b0;
      pidx_q     <= '0;
      eq_found_q <= 1'b0;
      gt_found_q <= 1'b0;
      eq_pos_q   <= '0;
      gt_pos_q   <= '0;
      pos_q      <= '0;
      sh_idx_q   <= '0;
      replaced_q <= 1'b0;
      evicted_q  <= 1'b0;
      skip_q     <= 1'b0;
    end else begin
      if (cap_wr_i && (fill_q > cap_new_i)) begin
        fill_q <= cap_new_i;
      end
      if (cmd_i.load) begin
        div_cnt_q <= DIVC_W'(DIV_STEPS);
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - DIVC_W'(1);
      end
      if (cmd_i.scan_init) begin
        rd_idx_q   <= '0;
        pv_q       <= 1'b0;
        eq_found_q <= 1'b0;
        gt_found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        pv_q <= scan_more;
        if (scan_more) begin
          pidx_q   <= rd_idx_q[IDX_W-1:0];
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (pv_q) begin
          if ((key_held == key_new) && !eq_found_q) begin
            eq_found_q <= 1'b1;
            eq_pos_q   <= pidx_q;
          end
          if ((key_held > key_new) && !gt_found_q) begin
            gt_found_q <= 1'b1;
            gt_pos_q   <= pidx_q;
          end
        end
      end
      if (cmd_i.decide) begin
        pos_q      <= pos_c;
        replaced_q <= eq_found_q;
        evicted_q  <= !eq_found_q && ((pos_c >= cap_i) || (fill_q >= cap_i));
        skip_q     <= !eq_found_q && (pos_c >= cap_i);
        if (!eq_found_q && (pos_c < cap_i)) begin
          if (fill_q < cap_i) begin
            fill_q   <= fill_q + CNT_W'(1);
            sh_idx_q <= fill_q;
          end else begin
            sh_idx_q <= cap_i - CNT_W'(1);
          end
        end
      end
      if (cmd_i.shift_wr) begin
        sh_idx_q <= sh_prev;
      end
    end
  end

  always_comb begin
    res_d             = '0;
    res_d.entry_count = 8'(fill_q);
    if (item_q.cmd == CMD_READ) begin
      if (rank_ok) begin
        res_d.entry_valid    = 1'b1;
        res_d.out_strict     = rdata_q.s;
        res_d.out_proxy      = rdata_q.p;
        res_d.out_xor        = rdata_q.x;
        res_d.out_calibrated = rdata_q.c;
        res_d.out_weight     = rdata_q.w;
        res_d.out_hash       = rdata_q.h;
        res_d.out_tag        = 16'(rdata_q.tag);
      end
    end else begin
      res_d.replaced = replaced_q;
      res_d.evicted  = evicted_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  always_comb begin
    sts_o.div_done   = (div_cnt_q == DIVC_W'(1));
    sts_o.scan_done  = !scan_more && !pv_q;
    sts_o.skip_write = skip_q;
    sts_o.replaced   = replaced_q;
    sts_o.shift_done = (sh_idx_q == pos_q);
  end

endmodule

/* rtl/bounded_top_k_ranker_top.sv */
// Top level of the bounded top-K ranker: APB registers, sequencer, datapath.
// Depends on rkq_pkg, rkq_if, rkq_ctrl and rkq_datapath.
//
//   channel  dir  handshake       payload
//   in_i     in   valid/ready     in_item_t (insert or read command)
//   out_o    out  valid/ready     out_item_t (one result beat per command)
//   apb      in   psel/penable    rank_mode at 0x0, capacity_limit at 0x4
//
// Read: the addressed entry is read, then loaded into the result register.
// Insert: score quotient by the split reciprocal multiply, scan, decide,
// shift of later entries (not on replace or skip), write (not on skip)
// and result, in the order set by the single-port memory and the multiply.
// Reset empties the store at once; no clearing pass.
// A result beat waits in the output register; the next command is taken
// meanwhile and its result is held back until that beat is taken.
module bounded_top_k_ranker_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rkq_in_if.sink                     in_i,
  rkq_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rkq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rkq_pkg::*;

  rank_mode_e  mode_q;
  logic [7:0]  cap_raw_q;
  logic        cfg_wr;
  logic        cap_wr;
  rkq_cmd_t    cmd;
  rkq_status_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cap_wr = cfg_wr && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_STRICT;
      cap_raw_q <= CAP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RANK_MODE) begin
        mode_q <= rank_mode_e'(pwdata[1:0]);
      end else begin
        cap_raw_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RANK_MODE: prdata = 32'(mode_q);
      REG_CAPACITY:  prdata = 32'(cap_raw_q);
      default:       prdata = '0;
    endcase
  end

  rkq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.data.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rkq_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (in_i.data),
    .mode_i    (mode_q),
    .cap_i     (eff_cap(cap_raw_q)),
    .cap_wr_i  (cap_wr),
    .cap_new_i (eff_cap(pwdata[7:0])),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (out_o.data)
  );

endmodule

/* rtl/rkq_checker.sv */
// Port-level checks of the ranker result channel, bound to the top level.
// Depends on rkq_pkg for the result layout.
module rkq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic entry_valid_i,
  input logic replaced_i,
  input logic evicted_i,
  input logic [7:0] entry_count_i
);
  import rkq_pkg::*;

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(replaced_i && evicted_i))
    else $error("replace and evict in one beat");

  a_read_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && entry_valid_i |-> !replaced_i && !evicted_i
      && (entry_count_i != 8'd0))
    else $error("read beat carries insert flags or empty count");

  a_replace_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && replaced_i |-> (entry_count_i != 8'd0))
    else $error("replace reported on empty store");

endmodule

bind bounded_top_k_ranker_top rkq_checker u_rkq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .entry_valid_i (out_o.data.entry_valid),
  .replaced_i    (out_o.data.replaced),
  .evicted_i     (out_o.data.evicted),
  .entry_count_i (out_o.data.entry_count)
);

/* bench/bounded_top_k_ranker_top_test.sv */
// Self-checking bench for bounded_top_k_ranker_top: random and directed insert/read beats,
// APB mode/capacity writes between phases, results checked against an in-bench ranked store.
// Depends on rkq_pkg, rkq_if and the ranker RTL.
module bounded_top_k_ranker_top_test;
  import rkq_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SHOWN_MAX  = 10;
  localparam int PHASE_LEN  = 150;

  typedef struct {
    logic [9:0]         s_cost;
    logic [9:0]         p_cost;
    logic [9:0]         x_cost;
    logic signed [47:0] cal;
    logic [11:0]        wt;
    logic [63:0]        hash;
    logic [15:0]        tag;
  } entry_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  rkq_in_if  in_bus ();
  rkq_out_if out_bus ();

  bounded_top_k_ranker_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  entry_t     ranked[MAX_ENTRIES];
  int         ranked_count;
  rank_mode_e cur_mode;
  logic [7:0] cap_raw;

  in_item_t   pending_cmds[$];
  out_item_t  expected_beats[$];
  in_item_t   recent_inserts[$];

  int issued;
  int accepted;
  int mismatches;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int rx_cycle;
  int rx_style;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int cap_now();
    if (cap_raw == 8'd0) begin
      return 1;
    end
    if (int'(cap_raw) > MAX_ENTRIES) begin
      return MAX_ENTRIES;
    end
    return int'(cap_raw);
  endfunction

  function automatic void key_of(entry_t e, output longint k[5]);
    longint c;
    longint q;
    c = e.cal;
    q = c / SCALE;
    case (cur_mode)
      MODE_STRICT: k = '{longint'(e.s_cost), longint'(e.p_cost), longint'(e.x_cost), q,
                         longint'(e.wt)};
      MODE_PROXY:  k = '{longint'(e.p_cost), longint'(e.s_cost), longint'(e.x_cost), q,
                         longint'(e.wt)};
      MODE_CALIB:  k = '{c, longint'(e.s_cost), longint'(e.p_cost), longint'(e.x_cost),
                         longint'(e.wt)};
      default:     k = '{longint'(e.x_cost), longint'(e.s_cost), longint'(e.p_cost), q,
                         longint'(e.wt)};
    endcase
  endfunction

  function automatic int key_cmp(entry_t a, entry_t b);
    longint ka[5];
    longint kb[5];
    key_of(a, ka);
    key_of(b, kb);
    for (int i = 0; i < 5; i++) begin
      if (ka[i] < kb[i]) return -1;
      if (ka[i] > kb[i]) return 1;
    end
    if (a.hash < b.hash) return -1;
    if (a.hash > b.hash) return 1;
    return 0;
  endfunction

  function automatic void rank_step(in_item_t it);
    out_item_t r;
    entry_t    cand;
    int        pos;
    int        cap;
    int        last;
    bit        hit;
    r = '0;
    if (it.cmd == CMD_READ) begin
      if (int'(it.rank_index) < ranked_count) begin
        r.entry_valid    = 1'b1;
        r.out_strict     = ranked[it.rank_index].s_cost;
        r.out_proxy      = ranked[it.rank_index].p_cost;
        r.out_xor        = ranked[it.rank_index].x_cost;
        r.out_calibrated = ranked[it.rank_index].cal;
        r.out_weight     = ranked[it.rank_index].wt;
        r.out_hash       = ranked[it.rank_index].hash;
        r.out_tag        = ranked[it.rank_index].tag;
      end
    end else begin
      cand.s_cost = it.strict_cost;
      cand.p_cost = it.proxy_cost;
      cand.x_cost = it.xor_cost;
      cand.cal    = it.calibrated_score;
      cand.wt     = it.weight_total;
      cand.hash   = it.hash_value;
      cand.tag    = it.tag;
      cap = cap_now();
      pos = ranked_count;
      hit = 1'b0;
      for (int i = 0; i < ranked_count; i++) begin
        if (key_cmp(ranked[i], cand) == 0) begin
          hit = 1'b1;
          pos = i;
          break;
        end
      end
      if (!hit) begin
        for (int i = 0; i < ranked_count; i++) begin
          if (key_cmp(ranked[i], cand) > 0) begin
            pos = i;
            break;
          end
        end
      end
      if (hit) begin
        r.replaced  = 1'b1;
        ranked[pos] = cand;
      end else if (pos >= cap) begin
        r.evicted = 1'b1;
      end else begin
        last = (ranked_count < cap) ? ranked_count : cap - 1;
        for (int i = last; i > pos; i--) begin
          ranked[i] = ranked[i-1];
        end
        if (ranked_count < cap) begin
          ranked_count++;
        end else begin
          r.evicted = 1'b1;
        end
        ranked[pos] = cand;
      end
    end
    r.entry_count = 8'(ranked_count);
    expected_beats = {expected_beats, r};
  endfunction

  function automatic void report(string fld, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX) begin
        $display("mismatch on %s: expected %h, got %h", fld, e, a);
      end
    end
  endfunction

  function automatic in_item_t mk(logic c, int s, int p, int x, longint cal, int w,
                                  logic [63:0] h, int tg, int rank);
    in_item_t it;
    it.cmd              = c;
    it.strict_cost      = 10'(s);
    it.proxy_cost       = 10'(p);
    it.xor_cost         = 10'(x);
    it.calibrated_score = 48'(cal);
    it.weight_total     = 12'(w);
    it.hash_value       = h;
    it.tag              = 16'(tg);
    it.rank_index       = 7'(rank);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    longint   c;
    longint   base;
    int       hi;
    it.cmd              = CMD_INSERT;
    it.strict_cost      = ($urandom_range(0, 2) == 0) ? 10'($urandom_range(0, 999))
                                                      : 10'($urandom_range(0, 3));
    it.proxy_cost       = ($urandom_range(0, 2) == 0) ? 10'($urandom_range(0, 999))
                                                      : 10'($urandom_range(0, 3));
    it.xor_cost         = ($urandom_range(0, 2) == 0) ? 10'($urandom_range(0, 999))
                                                      : 10'($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0: c = longint'($urandom_range(0, 6000)) - 3000;
      1: c = longint'({$urandom, $urandom});
      2: c = ($urandom_range(0, 1) == 0) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      default: c = longint'($urandom_range(0, 3)) * 1000 - 1500;
    endcase
    it.calibrated_score = 48'(c);
    it.weight_total     = ($urandom_range(0, 1) == 0) ? 12'($urandom)
                                                      : 12'($urandom_range(0, 2));
    it.hash_value       = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                                      : 64'($urandom_range(0, 3));
    it.tag              = 16'($urandom);
    it.rank_index       = 7'($urandom);
    if ($urandom_range(0, 99) < 25) begin
      it.cmd = CMD_READ;
      hi = (ranked_count + 1 > 127) ? 127 : ranked_count + 1;
      if ($urandom_range(0, 3) != 0) begin
        it.rank_index = 7'($urandom_range(0, hi));
      end
    end else if (recent_inserts.size() > 0 && $urandom_range(0, 3) == 0) begin
      it            = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
      it.tag        = 16'($urandom);
      it.rank_index = 7'($urandom);
      c = it.calibrated_score;
      if (cur_mode != MODE_CALIB && c < 64'sd70_000_000_000_000 &&
          c > -64'sd70_000_000_000_000) begin
        base = c - (c % SCALE);
        c    = (c >= 0) ? base + $urandom_range(0, 999) : base - $urandom_range(0, 999);
        it.calibrated_score = 48'(c);
      end
    end else begin
      recent_inserts = {recent_inserts, it};
      if (recent_inserts.size() > 16) begin
        void'(recent_inserts.pop_front());
      end
    end
    return it;
  endfunction

  task automatic apb_write(logic reg_sel, int val);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {reg_sel, 2'b00};
    pwdata  = 32'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (reg_sel == REG_RANK_MODE) begin
      cur_mode = rank_mode_e'(val[1:0]);
    end else begin
      cap_raw = 8'(val);
      if (ranked_count > cap_now()) begin
        ranked_count = cap_now();
      end
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || accepted != issued || expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // driver: bursts with random gaps, hold a beat until taken
  always @(negedge clk_i) begin
    if (rst_ni && !(in_bus.valid && accepted != issued)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_bus.data  <= pending_cmds.pop_front();
        in_bus.valid <= 1'b1;
        issued++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) begin
      rx_style = $urandom_range(0, 3);
    end
    case (rx_style)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= ($urandom_range(0, 9) < 6);
      2: out_bus.ready <= (rx_cycle % 4 == 0);
      default: out_bus.ready <= ((rx_cycle % 64) < 8);
    endcase
  end

  // monitor: check result beats, predict on accepted command beats
  always @(posedge clk_i) begin
    out_item_t exp_beat;
    out_item_t got;
    if (rst_ni) begin
      idle_cycles++;
      if (out_bus.valid && out_bus.ready) begin
        idle_cycles = 0;
        got = out_bus.data;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX) begin
            $display("result beat with nothing pending: %h", got);
          end
        end else begin
          exp_beat = expected_beats.pop_front();
          report("entry_valid", 64'(exp_beat.entry_valid), 64'(got.entry_valid));
          report("out_strict", 64'(exp_beat.out_strict), 64'(got.out_strict));
          report("out_proxy", 64'(exp_beat.out_proxy), 64'(got.out_proxy));
          report("out_xor", 64'(exp_beat.out_xor), 64'(got.out_xor));
          report("out_calibrated", 64'(exp_beat.out_calibrated), 64'(got.out_calibrated));
          report("out_weight", 64'(exp_beat.out_weight), 64'(got.out_weight));
          report("out_hash", exp_beat.out_hash, got.out_hash);
          report("out_tag", 64'(exp_beat.out_tag), 64'(got.out_tag));
          report("entry_count", 64'(exp_beat.entry_count), 64'(got.entry_count));
          report("replaced", 64'(exp_beat.replaced), 64'(got.replaced));
          report("evicted", 64'(exp_beat.evicted), 64'(got.evicted));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        idle_cycles = 0;
        rank_step(in_bus.data);
        accepted++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int caps[12];
    caps = '{1, 2, 3, 8, 16, 5, 128, 0, 200, 255, 12, 4};
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    ranked_count  = 0;
    cur_mode      = MODE_STRICT;
    cap_raw       = CAP_RESET;
    issued        = 0;
    accepted      = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    gap_left      = 0;
    rx_cycle      = 0;
    rx_style      = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    pending_cmds = {pending_cmds, mk(CMD_READ, 0, 0, 0, 0, 0, 64'd0, 0, 0)};
    pending_cmds = {pending_cmds, mk(CMD_INSERT, 0, 0, 0, 0, 0, 64'd0, 1, 0)};
    pending_cmds = {pending_cmds, mk(CMD_INSERT, 999, 999, 999, 48'h7FFF_FFFF_FFFF, 4095,
                                     '1, 16'hFFFF, 127)};
    pending_cmds = {pending_cmds, mk(CMD_INSERT, 500, 1, 2, -64'sd140737488355328, 7,
                                     64'h8000_0000_0000_0000, 3, 0)};
    pending_cmds = {pending_cmds, mk(CMD_INSERT, 0, 0, 0, 999, 0, 64'd0, 2, 0)};
    pending_cmds = {pending_cmds, mk(CMD_INSERT, 5, 0, 0, -1500, 0, 64'd9, 4, 0)};
    pending_cmds = {pending_cmds, mk(CMD_INSERT, 5, 0, 0, -1999, 0, 64'd9, 5, 0)};
    for (int i = 0; i < 5; i++) begin
      pending_cmds = {pending_cmds, mk(CMD_READ, 0, 0, 0, 0, 0, 64'd0, 0, i)};
    end
    pending_cmds = {pending_cmds, mk(CMD_READ, 0, 0, 0, 0, 0, 64'd0, 0, 127)};
    drain();

    apb_write(REG_RANK_MODE, MODE_CALIB);
    apb_write(REG_CAPACITY, 2);
    pending_cmds = {pending_cmds, mk(CMD_INSERT, 1, 1, 1, 48'h7FFF_FFFF_FFFF, 1, '1, 6, 0)};
    pending_cmds = {pending_cmds, mk(CMD_INSERT, 1, 1, 1, -64'sd140737488355328, 0, 64'd0,
                                     7, 0)};
    pending_cmds = {pending_cmds, mk(CMD_READ, 0, 0, 0, 0, 0, 64'd0, 0, 0)};
    pending_cmds = {pending_cmds, mk(CMD_READ, 0, 0, 0, 0, 0, 64'd0, 0, 1)};
    pending_cmds = {pending_cmds, mk(CMD_READ, 0, 0, 0, 0, 0, 64'd0, 0, 2)};
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      apb_write(REG_RANK_MODE, ph % 4);
      apb_write(REG_CAPACITY, caps[ph]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        pending_cmds = {pending_cmds, rand_item()};
      end
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* bounded_top_k_ranker_top.f */
rtl/rkq_pkg.sv
rtl/rkq_if.sv
rtl/rkq_ctrl.sv
rtl/rkq_datapath.sv
rtl/bounded_top_k_ranker_top.sv
rtl/rkq_checker.sv
bench/bounded_top_k_ranker_top_test.sv
